[design/dcrr_pkg.sv]
`default_nettype none

package dcrr_pkg;

    // One day in milliseconds; a single subtraction wraps any 27-bit time
    localparam logic [26:0] DAY_MS = 27'd86400000;

    // Reciprocal constants: floor(x / d) = (x * RECIP) >> SHIFT, exact over the used range
    // Seconds: (t >> 3) / 125, t below one day
    localparam logic [24:0] RECIP_125  = 25'd17179870;
    localparam int          SHIFT_125  = 31;
    // Minutes: (x >> 2) / 15, x below 86400 seconds
    localparam logic [15:0] RECIP_15_S = 16'd34953;
    localparam int          SHIFT_15_S = 19;
    // Hours: (x >> 2) / 15, x below 1440 minutes
    localparam logic [9:0]  RECIP_15_M = 10'd547;
    localparam int          SHIFT_15_M = 13;

    // Border timing in seconds
    localparam logic signed [7:0] TOP_RIGHT_END  = 8'sd7;
    localparam logic signed [7:0] RIGHT_END      = 8'sd23;
    localparam logic signed [7:0] BOTTOM_START   = 8'sd21;
    localparam logic signed [7:0] LEFT_START     = 8'sd36;
    localparam logic signed [7:0] TOP_LEFT_END   = 8'sd67;
    localparam logic [5:0]        TOP_LEFT_START = 6'd51;
    localparam logic [15:0]       TOP_RIGHT_MASK = 16'h00FF;

    // Row layout
    localparam logic [3:0] ROW_TOP      = 4'd0;
    localparam logic [3:0] ROW_BOTTOM   = 4'd15;
    localparam logic [3:0] ROW_HRS_TOP  = 4'd2;
    localparam logic [3:0] ROW_MINS_TOP = 4'd9;

    // Decoded time handed from the divider pipeline to the renderer
    typedef struct packed {
        logic [5:0] sec;
        logic [3:0] hrs_tens;
        logic [3:0] hrs_units;
        logic [5:0] mins;
    } t_time_fields;

    // Tens digit of a value below 64
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        if (v >= 6'd60)      return 4'd6;
        else if (v >= 6'd50) return 4'd5;
        else if (v >= 6'd40) return 4'd4;
        else if (v >= 6'd30) return 4'd3;
        else if (v >= 6'd20) return 4'd2;
        else if (v >= 6'd10) return 4'd1;
        else                 return 4'd0;
    endfunction

    // Units digit of a value below 64
    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] t10;
        t10 = 6'(tens_of(v)) * 6'd10;
        return 4'(v - t10);
    endfunction

    // 5x3 font, digit taken modulo 10
    function automatic logic [14:0] glyph(input logic [3:0] d);
        case (d)
            4'd0, 4'd10: return 15'h7B6F;
            4'd1, 4'd11: return 15'h2492;
            4'd2, 4'd12: return 15'h73E7;
            4'd3, 4'd13: return 15'h73CF;
            4'd4, 4'd14: return 15'h5BC9;
            4'd5, 4'd15: return 15'h79CF;
            4'd6:        return 15'h79EF;
            4'd7:        return 15'h7249;
            4'd8:        return 15'h7BEF;
            4'd9:        return 15'h7BCF;
            default:     return 15'h7B6F;
        endcase
    endfunction

    // Three pixels of digit row r, 0 top .. 4 bottom
    function automatic logic [2:0] glyph_row(input logic [3:0] d, input logic [2:0] r);
        logic [14:0] g;
        g = glyph(d);
        case (r)
            3'd0:    return g[14:12];
            3'd1:    return g[11:9];
            3'd2:    return g[8:6];
            3'd3:    return g[5:3];
            3'd4:    return g[2:0];
            default: return 3'd0;
        endcase
    endfunction

    // Low k bits set, k clamped to 0..16
    function automatic logic [15:0] low_ones(input logic signed [7:0] k);
        logic [16:0] m;
        m = (17'd1 << k[3:0]) - 17'd1;
        if (k <= 8'sd0)       return 16'h0000;
        else if (k >= 8'sd16) return 16'hFFFF;
        else                  return m[15:0];
    endfunction

endpackage

`default_nettype wire

[design/dcrr_time_split.sv]
`default_nettype none

// Five-stage split of milliseconds into seconds, minutes and hour digits
module dcrr_time_split
    import dcrr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [26:0]  i_time_ms,
    input  wire logic [3:0]   i_row,
    output logic              o_valid,
    output logic [3:0]        o_row,
    output t_time_fields      o_fields
);

    // Stage registers
    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [3:0]  r_row1, r_row2, r_row3, r_row4, r_row5;
    logic [26:0] r_t1;
    logic [16:0] r_tsec2, r_tsec3;
    logic [10:0] r_tmin3, r_tmin4;
    logic [5:0]  r_sec4, r_sec5;
    logic [4:0]  r_hrs4;
    logic [5:0]  r_mins5;
    logic [3:0]  r_htens5, r_hunits5;

    logic [26:0] n_t1;
    logic [48:0] n_prod2;
    logic [30:0] n_prod3;
    logic [18:0] n_prod4;
    logic [16:0] n_min60_4;
    logic [16:0] n_sec4_full;
    logic [10:0] n_hrs60_5;
    logic [10:0] n_mins5_full;
    logic [5:0]  n_hrs5;

    // Stage 1: wrap past one day
    assign n_t1 = (i_time_ms >= DAY_MS) ? (i_time_ms - DAY_MS) : i_time_ms;

    // Stage 2: seconds since midnight
    assign n_prod2 = 49'(r_t1[26:3]) * 49'(RECIP_125);

    // Stage 3: minutes since midnight
    assign n_prod3 = 31'(r_tsec2[16:2]) * 31'(RECIP_15_S);

    // Stage 4: seconds within the minute, hours
    assign n_min60_4   = 17'({r_tmin3, 6'b0}) - 17'({r_tmin3, 2'b0});
    assign n_sec4_full = r_tsec3 - n_min60_4;
    assign n_prod4     = 19'(r_tmin3[10:2]) * 19'(RECIP_15_M);

    // Stage 5: minutes within the hour, hour digits
    assign n_hrs60_5    = 11'({r_hrs4, 6'b0}) - 11'({r_hrs4, 2'b0});
    assign n_mins5_full = r_tmin4 - n_hrs60_5;
    assign n_hrs5       = {1'b0, r_hrs4};

    // Valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        r_t1      <= n_t1;
        r_row1    <= i_row;
        r_tsec2   <= n_prod2[SHIFT_125 +: 17];
        r_row2    <= r_row1;
        r_tsec3   <= r_tsec2;
        r_tmin3   <= n_prod3[SHIFT_15_S +: 11];
        r_row3    <= r_row2;
        r_sec4    <= n_sec4_full[5:0];
        r_hrs4    <= n_prod4[SHIFT_15_M +: 5];
        r_tmin4   <= r_tmin3;
        r_row4    <= r_row3;
        r_sec5    <= r_sec4;
        r_mins5   <= n_mins5_full[5:0];
        r_htens5  <= tens_of(n_hrs5);
        r_hunits5 <= units_of(n_hrs5);
        r_row5    <= r_row4;
    end

    assign o_valid            = r_v5;
    assign o_row              = r_row5;
    assign o_fields.sec       = r_sec5;
    assign o_fields.hrs_tens  = r_htens5;
    assign o_fields.hrs_units = r_hunits5;
    assign o_fields.mins      = r_mins5;

endmodule

`default_nettype wire

[design/digital_clock_row_renderer.sv]
`default_nettype none

// Digital clock row renderer for a 16x16 LED matrix.
// A request carries a time of day in milliseconds and a row number; the block
// answers with that row's 16-bit pixel word (bit 15 is the leftmost column).
// Hours sit on rows 2..6, minutes on rows 9..13, and a border fills clockwise
// with the seconds from the top center.
// Request channel: a transaction is taken at a rising edge with start high and
// busy low. busy is held low: the pipeline never stalls, so a request may be
// issued on every cycle.
// Result channel: o_valid is high for exactly one cycle with o_row_bits; the
// receiver takes it at the edge ending that cycle and cannot hold it off.
// A request passes six register stages (five of wrap, reciprocal multiplies and
// digit split, one render; the first loads on the accepting edge), and o_valid
// rises as the last one loads.
// Throughput: one result per cycle, set by the fully pipelined datapath.
// Reset (i_rst_n low, synchronous) clears all valid bits; requests in flight are
// dropped and no result is shown until a new request passes through.
module digital_clock_row_renderer
    import dcrr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [26:0]  i_time_ms,
    input  wire logic [3:0]   i_row_index,
    output logic              o_valid,
    output logic [15:0]       o_row_bits
);

    logic         s_valid;
    logic [3:0]   s_row;
    t_time_fields s_fields;

    logic         r_valid;
    logic [15:0]  r_row_bits;
    logic [15:0]  n_row_bits;

    logic signed [7:0] s8;
    logic [15:0]  rb;
    logic [15:0]  lb;
    logic [3:0]   rb_idx;
    logic [3:0]   lb_idx;
    logic [2:0]   dig_row;
    logic [3:0]   mins_tens;
    logic [3:0]   mins_units;

    assign busy = 1'b0;

    // Time decomposition pipeline
    dcrr_time_split u_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start),
        .i_time_ms (i_time_ms),
        .i_row     (i_row_index),
        .o_valid   (s_valid),
        .o_row     (s_row),
        .o_fields  (s_fields)
    );

    assign mins_tens  = tens_of(s_fields.mins);
    assign mins_units = units_of(s_fields.mins);

    // Border bars and digits for the requested row
    always_comb begin
        s8         = $signed({2'b00, s_fields.sec});
        rb         = ~low_ones(RIGHT_END - s8);
        lb         = low_ones(s8 - LEFT_START);
        rb_idx     = 4'(5'd16 - {1'b0, s_row});
        lb_idx     = ~s_row;
        dig_row    = 3'd0;
        n_row_bits = 16'h0000;

        if (s_row == ROW_TOP) begin
            n_row_bits = ~low_ones(TOP_RIGHT_END - s8) & TOP_RIGHT_MASK;
            if (s_fields.sec > TOP_LEFT_START)
                n_row_bits = n_row_bits | ~low_ones(TOP_LEFT_END - s8);
        end else if (s_row == ROW_BOTTOM) begin
            if (s8 > BOTTOM_START)
                n_row_bits = low_ones(s8 - BOTTOM_START);
        end else begin
            if (s8 > TOP_RIGHT_END)
                n_row_bits[0] = rb[rb_idx];
            if (s8 > LEFT_START)
                n_row_bits[15] = lb[lb_idx];
        end

        // Hours and minutes digits
        if (s_row inside {[4'd2:4'd6]}) begin
            dig_row          = 3'(s_row - ROW_HRS_TOP);
            n_row_bits[11:9] = n_row_bits[11:9] | glyph_row(s_fields.hrs_tens, dig_row);
            n_row_bits[6:4]  = n_row_bits[6:4] | glyph_row(s_fields.hrs_units, dig_row);
        end else if (s_row inside {[4'd9:4'd13]}) begin
            dig_row          = 3'(s_row - ROW_MINS_TOP);
            n_row_bits[11:9] = n_row_bits[11:9] | glyph_row(mins_tens, dig_row);
            n_row_bits[6:4]  = n_row_bits[6:4] | glyph_row(mins_units, dig_row);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_bits <= n_row_bits;
    end

    assign o_valid    = r_valid;
    assign o_row_bits = r_row_bits;

endmodule

`default_nettype wire

[bench/digital_clock_row_renderer_checker.sv]
`timescale 1ns / 100ps

module digital_clock_row_renderer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [26:0] i_time_ms,
    input  logic [3:0]  i_row_index,
    input  logic        i_valid,
    input  logic [15:0] i_row_bits,
    output int          o_mismatches,
    output int          o_outstanding
);

    localparam int unsigned MS_PER_DAY  = 86400000;
    localparam int          MAX_REPORTS = 10;

    // Layout of the face
    localparam int ROW_TOP       = 0;
    localparam int ROW_BOTTOM    = 15;
    localparam int ROW_HRS_FIRST = 2;
    localparam int ROW_HRS_LAST  = 6;
    localparam int ROW_MIN_FIRST = 9;
    localparam int ROW_MIN_LAST  = 13;
    localparam int TENS_COL      = 9;
    localparam int UNITS_COL     = 4;

    // Border timing, in seconds
    localparam int SEC_TOP_RIGHT  = 7;
    localparam int SEC_RIGHT      = 23;
    localparam int SEC_BOTTOM     = 21;
    localparam int SEC_LEFT       = 36;
    localparam int SEC_TOP_LEFT_0 = 51;
    localparam int SEC_TOP_LEFT   = 67;

    typedef struct {
        logic [26:0] time_ms;
        logic [3:0]  row;
        logic [15:0] word;
    } row_request_t;

    row_request_t pending_rows[$];

    // 5x3 digit font, top row in the high bits
    function automatic logic [15:0] font_bits(input int unsigned d);
        case (d % 10)
            0: return 16'h7B6F;
            1: return 16'h2492;
            2: return 16'h73E7;
            3: return 16'h73CF;
            4: return 16'h5BC9;
            5: return 16'h79CF;
            6: return 16'h79EF;
            7: return 16'h7249;
            8: return 16'h7BEF;
            default: return 16'h7BCF;
        endcase
    endfunction

    // Low k bits set, k clamped to 0..16
    function automatic logic [31:0] fill_mask(input int k);
        int kc;
        kc = (k < 0) ? 0 : ((k > 16) ? 16 : k);
        return (32'd1 << kc) - 32'd1;
    endfunction

    function automatic logic [31:0] digit_slice(input int unsigned d, input int unsigned r);
        return ({16'd0, font_bits(d)} >> ((4 - r) * 3)) & 32'd7;
    endfunction

    // Expected pixel word for one request
    function automatic logic [15:0] render_row_word(input logic [26:0] t_in,
                                                    input logic [3:0] row_in);
        int unsigned t;
        int unsigned tot_s;
        int unsigned tot_m;
        int unsigned hrs;
        int unsigned mins;
        int          s;
        int          row;
        logic [31:0] word;
        logic [31:0] bar;
        t = t_in;
        row = row_in;
        word = '0;
        if (t >= MS_PER_DAY) t = t - MS_PER_DAY;
        tot_s = t / 1000;
        s = tot_s % 60;
        tot_m = tot_s / 60;
        mins = tot_m % 60;
        hrs = tot_m / 60;

        // Seconds border
        if (row == ROW_TOP) begin
            word |= ~fill_mask(SEC_TOP_RIGHT - s) & 32'h00FF;
            if (s > SEC_TOP_LEFT_0) word |= ~fill_mask(SEC_TOP_LEFT - s) & 32'hFFFF;
        end else if (row == ROW_BOTTOM) begin
            if (s > SEC_BOTTOM) word |= fill_mask(s - SEC_BOTTOM);
        end else begin
            if (s > SEC_TOP_RIGHT) begin
                bar = ~fill_mask(SEC_RIGHT - s) & 32'hFFFF;
                word |= (bar >> (16 - row)) & 32'd1;
            end
            if (s > SEC_LEFT) begin
                bar = fill_mask(s - SEC_LEFT);
                word |= (bar << row) & 32'h8000;
            end
        end

        // Digits
        if (row >= ROW_HRS_FIRST && row <= ROW_HRS_LAST) begin
            word |= digit_slice(hrs / 10, row - ROW_HRS_FIRST) << TENS_COL;
            word |= digit_slice(hrs % 10, row - ROW_HRS_FIRST) << UNITS_COL;
        end else if (row >= ROW_MIN_FIRST && row <= ROW_MIN_LAST) begin
            word |= digit_slice(mins / 10, row - ROW_MIN_FIRST) << TENS_COL;
            word |= digit_slice(mins % 10, row - ROW_MIN_FIRST) << UNITS_COL;
        end
        return word[15:0];
    endfunction

    initial begin
        o_mismatches = 0;
        o_outstanding = 0;
    end

    // Compare results first, then log newly accepted requests
    always @(posedge i_clk) begin
        row_request_t req;
        int           errs;
        errs = o_mismatches;
        if (i_rst_n === 1'b1) begin
            if (i_valid === 1'b1) begin
                if (pending_rows.size() == 0) begin
                    errs++;
                    if (errs <= MAX_REPORTS)
                        $display("[%0t] unexpected result row_bits=%h", $realtime, i_row_bits);
                end else begin
                    req = pending_rows.pop_front();
                    if (i_row_bits !== req.word) begin
                        errs++;
                        if (errs <= MAX_REPORTS)
                            $display("[%0t] time_ms=%0d row=%0d: expected %h, got %h",
                                     $realtime, req.time_ms, req.row, req.word, i_row_bits);
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                req.time_ms = i_time_ms;
                req.row = i_row_index;
                req.word = render_row_word(i_time_ms, i_row_index);
                pending_rows.push_back(req);
            end
        end
        o_mismatches <= errs;
        o_outstanding <= pending_rows.size();
    end

endmodule

[bench/digital_clock_row_renderer_tb.sv]
`timescale 1ns / 100ps

module digital_clock_row_renderer_tb;

    localparam int RANDOM_ITEMS  = 1730;
    localparam int DRAIN_AT      = 900;
    localparam int MAX_GAP       = 11;
    localparam int PHASE_LEN     = 64;
    localparam int TAIL_CYCLES   = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int unsigned MS_PER_DAY = 86400000;
    localparam int unsigned TIME_MAX   = 134217727;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [26:0] i_time_ms;
    logic [3:0]  i_row_index;
    logic        o_valid;
    logic [15:0] o_row_bits;
    int          mismatches;
    int          outstanding;
    int          cycles;
    bit          no_idle;

    digital_clock_row_renderer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_time_ms   (i_time_ms),
        .i_row_index (i_row_index),
        .o_valid     (o_valid),
        .o_row_bits  (o_row_bits)
    );

    digital_clock_row_renderer_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_time_ms     (i_time_ms),
        .i_row_index   (i_row_index),
        .i_valid       (o_valid),
        .i_row_bits    (o_row_bits),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One request transaction, then a random idle gap that may be empty
    task automatic send_request(input logic [26:0] t, input logic [3:0] row);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        start <= 1'b1;
        i_time_ms <= t;
        i_row_index <= row;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Random time: composed clock fields, flat within a day, or the full 27-bit range
    function automatic logic [26:0] random_time();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return 27'(((($urandom_range(0, 23) * 60 + $urandom_range(0, 59)) * 60
                        + $urandom_range(0, 59)) * 1000) + $urandom_range(0, 999));
        else if (sel < 8)
            return 27'($urandom_range(0, MS_PER_DAY - 1));
        else
            return 27'($urandom_range(0, TIME_MAX));
    endfunction

    initial begin
        cycles = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_time_ms = '0;
        i_row_index = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, day wrap, empty rows, bar edges
        send_request(27'd0, 4'd0);
        send_request(27'd0, 4'd15);
        send_request(27'd0, 4'd1);
        send_request(27'd86399999, 4'd0);
        send_request(27'd86399999, 4'd15);
        send_request(27'd86399999, 4'd8);
        send_request(27'd86400000, 4'd3);
        send_request(27'(TIME_MAX), 4'd10);
        send_request(27'(TIME_MAX), 4'd14);
        send_request(27'd7000, 4'd0);
        send_request(27'd8000, 4'd1);
        send_request(27'd21000, 4'd15);
        send_request(27'd22000, 4'd15);
        send_request(27'd23000, 4'd14);
        send_request(27'd36000, 4'd14);
        send_request(27'd37000, 4'd14);
        send_request(27'd51000, 4'd0);
        send_request(27'd52000, 4'd0);
        send_request(27'd59999, 4'd7);
        send_request(27'd45296000, 4'd4);
        send_request(27'd45296000, 4'd11);
        send_request(27'd39510000, 4'd2);
        send_request(27'd61785000, 4'd13);
        send_request(27'd72000000, 4'd6);

        // Random traffic, with back-to-back stretches mixed in
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) no_idle = ($urandom_range(0, 2) == 0);
            if (n == DRAIN_AT) begin
                @(negedge i_clk);
                start <= 1'b0;
                while (outstanding != 0) @(negedge i_clk);
            end
            send_request(random_time(), 4'($urandom_range(0, 15)));
        end

        // Drain and settle
        @(negedge i_clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[digital_clock_row_renderer.f]
design/dcrr_pkg.sv
design/dcrr_time_split.sv
design/digital_clock_row_renderer.sv
bench/digital_clock_row_renderer_checker.sv
bench/digital_clock_row_renderer_tb.sv
